/* rtl/kcsm_pkg.sv */
// Shared types, constants and helpers for the key combination sequence matcher.
// No dependencies; rtl/ files but kcsm_fifo refer to this package by scoped names.
`default_nettype none

package kcsm_pkg;

    // Parameter defaults
    localparam int NUM_SHORTCUTS_DEF = 4;
    localparam int MAX_KEYS_DEF      = 8;
    localparam int NUM_PROFILES_DEF  = 4;

    // Fixed field widths and register slots
    localparam int KEY_W       = 8;
    localparam int POS_W       = 4;
    localparam int PROF_W      = 2;
    localparam int SLOT_COUNT  = 4;   // shortcut slots held in the registers
    localparam int KEY_SLOTS   = 8;   // key codes per pattern register
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Queue depths
    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 4;

    // Request operation
    typedef enum logic {
        OP_KEY = 1'b0,
        OP_SET = 1'b1
    } t_op;

    // Action codes, shared by mapping bytes and results
    typedef enum logic [1:0] {
        ACT_NEXT  = 2'd0,
        ACT_PREV  = 2'd1,
        ACT_RESET = 2'd2,
        ACT_SET   = 2'd3
    } t_action;

    // In a mapping byte the top action code is the silent group action
    localparam t_action ACT_GROUP = ACT_SET;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEYS_0    = 3'd0,
        CFG_KEYS_1    = 3'd1,
        CFG_KEYS_2    = 3'd2,
        CFG_KEYS_3    = 3'd3,
        CFG_LENGTHS   = 3'd4,
        CFG_MAP_LOW   = 3'd5,
        CFG_MAP_HIGH  = 3'd6,
        CFG_TOP_PROF  = 3'd7
    } t_cfg_index;

    // Sequencer states of the back part
    typedef enum logic {
        SEQ_SCAN  = 1'b0,
        SEQ_FLUSH = 1'b1
    } t_seq_state;

    // Input request
    typedef struct packed {
        t_op                operation;
        logic [KEY_W-1:0]   key_code;
        logic [PROF_W-1:0]  profile_value;
    } t_item;

    // Result
    typedef struct packed {
        t_action            action;
        logic [PROF_W-1:0]  profile_now;
        logic               last;
    } t_result;

    // Classified request between front and back
    typedef struct packed {
        logic               is_set;
        logic [KEY_W-1:0]   key_code;
        logic [PROF_W-1:0]  set_profile;
    } t_cmd;

    // One mapping byte
    typedef struct packed {
        logic               enable;
        t_action            action;
        logic               shift;
        logic [POS_W-1:0]   shift_point;
    } t_map;

    // Configuration register file
    typedef struct packed {
        logic [SLOT_COUNT-1:0][KEY_SLOTS-1:0][KEY_W-1:0] pattern_keys;
        logic [SLOT_COUNT-1:0][POS_W-1:0]                pattern_lengths;
        logic [7:0][7:0]                                 mapping_low;
        logic [7:0][7:0]                                 mapping_high;
        logic [PROF_W-1:0]                               top_profile;
    } t_cfg;

    // Highest profile in use: the smaller of top_profile and the build limit
    function automatic logic [PROF_W-1:0] limit_profile(
        input logic [PROF_W-1:0] top,
        input logic [PROF_W-1:0] max_prof
    );
        return (top > max_prof) ? max_prof : top;
    endfunction

endpackage

`default_nettype wire

/* rtl/key_combo_sequence_matcher.sv */
// Top level of the key combination sequence matcher: configuration registers,
// front, command queue, back and result queue. Depends on kcsm_pkg and kcsm_* modules.
//
//  channel   direction  handshake                   payload
//  request   in         push / full                 i_item   (kcsm_pkg::t_item)
//  result    out        pop / empty                 o_result (kcsm_pkg::t_result)
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A key request is walked in the back part one shortcut per cycle while the result
// queue has room, plus a SEQ_FLUSH step when the last shortcut fires after an earlier
// fire of the same request; a set request completes in SEQ_SCAN. Results reach the
// result ports through the front register, command queue and result queue, and a key
// result may also wait in the pending register. Front register, command queue and
// result queue stall independently; the back part pauses on a full result queue.
// Synchronous active-low reset clears positions, profile, queues and registers.
`default_nettype none

module key_combo_sequence_matcher #(
    parameter int NUM_SHORTCUTS = kcsm_pkg::NUM_SHORTCUTS_DEF,
    parameter int MAX_KEYS      = kcsm_pkg::MAX_KEYS_DEF,
    parameter int NUM_PROFILES  = kcsm_pkg::NUM_PROFILES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire kcsm_pkg::t_item                     i_item,
    output logic                                     empty,
    input  wire logic                                pop,
    output kcsm_pkg::t_result                        o_result,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [kcsm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [kcsm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    kcsm_pkg::t_cfg     r_cfg;
    logic               w_cmd_push, w_cmd_full, w_cmd_pop, w_cmd_empty;
    kcsm_pkg::t_cmd     w_cmd_in, w_cmd_out;
    logic               w_res_push, w_res_full;
    kcsm_pkg::t_result  w_res;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (kcsm_pkg::t_cfg_index'(i_cfg_index))
                kcsm_pkg::CFG_KEYS_0:   r_cfg.pattern_keys[0] <= i_cfg_data;
                kcsm_pkg::CFG_KEYS_1:   r_cfg.pattern_keys[1] <= i_cfg_data;
                kcsm_pkg::CFG_KEYS_2:   r_cfg.pattern_keys[2] <= i_cfg_data;
                kcsm_pkg::CFG_KEYS_3:   r_cfg.pattern_keys[3] <= i_cfg_data;
                kcsm_pkg::CFG_LENGTHS:  r_cfg.pattern_lengths <= i_cfg_data[15:0];
                kcsm_pkg::CFG_MAP_LOW:  r_cfg.mapping_low     <= i_cfg_data;
                kcsm_pkg::CFG_MAP_HIGH: r_cfg.mapping_high    <= i_cfg_data;
                kcsm_pkg::CFG_TOP_PROF: r_cfg.top_profile     <= i_cfg_data[kcsm_pkg::PROF_W-1:0];
                default:                r_cfg                 <= r_cfg;
            endcase
        end
    end

    // Front: accept and classify
    kcsm_front #(
        .NUM_PROFILES (NUM_PROFILES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_item        (i_item),
        .i_top_profile (r_cfg.top_profile),
        .o_cmd_push    (w_cmd_push),
        .o_cmd         (w_cmd_in),
        .i_cmd_full    (w_cmd_full)
    );

    // Command queue between front and back
    kcsm_fifo #(
        .WIDTH ($bits(kcsm_pkg::t_cmd)),
        .DEPTH (kcsm_pkg::CMD_QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    // Back: shortcut walk
    kcsm_back #(
        .NUM_SHORTCUTS (NUM_SHORTCUTS),
        .MAX_KEYS      (MAX_KEYS),
        .NUM_PROFILES  (NUM_PROFILES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    // Result queue
    kcsm_fifo #(
        .WIDTH ($bits(kcsm_pkg::t_result)),
        .DEPTH (kcsm_pkg::RES_QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

`ifndef SYNTHESIS
    // back never writes a full result queue
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result written while queue full");

    // back only retires a command that is present
    a_cmd_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_empty)
        else $error("command retired from empty queue");

    // a set request yields exactly one result, so it is always the final one
    a_set_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && (w_res.action == kcsm_pkg::ACT_SET)) |-> w_res.last)
        else $error("profile set result without last flag");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");
`endif

endmodule

`default_nettype wire

/* rtl/kcsm_fifo.sv */
// Small synchronous queue of registers, one write and one read port.
// Uses no package items; instanced twice by key_combo_sequence_matcher.
`default_nettype none

module kcsm_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_wr, w_rd;

    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/kcsm_front.sv */
// Front part: takes input requests into a register stage and classifies them.
// Depends on kcsm_pkg; feeds the command queue in key_combo_sequence_matcher.
`default_nettype none

module kcsm_front #(
    parameter int NUM_PROFILES = kcsm_pkg::NUM_PROFILES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire kcsm_pkg::t_item               i_item,
    input  wire logic [kcsm_pkg::PROF_W-1:0]   i_top_profile,
    output logic                               o_cmd_push,
    output kcsm_pkg::t_cmd                     o_cmd,
    input  wire logic                          i_cmd_full
);

    localparam logic [kcsm_pkg::PROF_W-1:0] MAX_PROF = kcsm_pkg::PROF_W'(NUM_PROFILES - 1);

    logic                          r_valid;
    kcsm_pkg::t_cmd                r_cmd;
    kcsm_pkg::t_cmd                w_cmd;
    logic [kcsm_pkg::PROF_W-1:0]   w_lim;
    logic                          w_take;

    // Stage is free when empty or draining this cycle
    assign full       = r_valid && i_cmd_full;
    assign w_take     = push && !full;
    assign o_cmd_push = r_valid;
    assign o_cmd      = r_cmd;

    // Classify: a set request resolves its target profile here
    always_comb begin
        w_lim             = kcsm_pkg::limit_profile(i_top_profile, MAX_PROF);
        w_cmd.is_set      = (i_item.operation == kcsm_pkg::OP_SET);
        w_cmd.key_code    = i_item.key_code;
        w_cmd.set_profile = (i_item.profile_value > w_lim) ? '0 : i_item.profile_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (!i_cmd_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= w_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/kcsm_back.sv */
// Back part: walks a request's shortcuts, one per unstalled cycle; emits results.
// Depends on kcsm_pkg; reads the command queue and writes the result queue.
`default_nettype none

module kcsm_back #(
    parameter int NUM_SHORTCUTS = kcsm_pkg::NUM_SHORTCUTS_DEF,
    parameter int MAX_KEYS      = kcsm_pkg::MAX_KEYS_DEF,
    parameter int NUM_PROFILES  = kcsm_pkg::NUM_PROFILES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire kcsm_pkg::t_cfg    i_cfg,
    input  wire logic              i_cmd_empty,
    input  wire kcsm_pkg::t_cmd    i_cmd,
    output logic                   o_cmd_pop,
    input  wire logic              i_res_full,
    output logic                   o_res_push,
    output kcsm_pkg::t_result      o_res
);

    localparam int IDX_W = (NUM_SHORTCUTS > 1) ? $clog2(NUM_SHORTCUTS) : 1;
    localparam int PW    = kcsm_pkg::POS_W;
    localparam int FW    = kcsm_pkg::PROF_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SHORTCUTS - 1);
    localparam logic [FW-1:0]    MAX_PROF = FW'(NUM_PROFILES - 1);
    localparam logic [PW-1:0]    MAX_LEN  = PW'(MAX_KEYS);

    kcsm_pkg::t_seq_state  r_state, n_state;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [PW-1:0]         r_pos [NUM_SHORTCUTS];
    logic [PW-1:0]         n_pos [NUM_SHORTCUTS];
    logic [FW-1:0]         r_prof, n_prof;
    logic                  r_pend_valid, n_pend_valid;
    kcsm_pkg::t_result     r_pend, n_pend;

    logic [1:0]            w_sel;
    kcsm_pkg::t_map        w_map;
    logic [PW-1:0]         w_len, w_pos, w_pos_inc, w_new_pos;
    logic                  w_hit, w_shift_fire, w_done, w_fire, w_vis;
    logic [FW-1:0]         w_lim, w_fire_prof;
    logic                  w_last_step;
    kcsm_pkg::t_result     w_fire_res;

    // Evaluate the shortcut under the cursor against the current key
    always_comb begin
        w_sel = 2'(r_idx);
        w_map = kcsm_pkg::t_map'(r_prof[1] ? i_cfg.mapping_high[{r_prof[0], w_sel}]
                                           : i_cfg.mapping_low[{r_prof[0], w_sel}]);
        w_len = (i_cfg.pattern_lengths[w_sel] > MAX_LEN) ? MAX_LEN
                                                          : i_cfg.pattern_lengths[w_sel];
        w_pos        = r_pos[r_idx];
        w_hit        = (w_pos < w_len) &&
                       (i_cfg.pattern_keys[w_sel][w_pos[2:0]] == i_cmd.key_code);
        w_pos_inc    = w_pos + PW'(1);
        w_shift_fire = w_map.shift && (w_pos_inc == w_map.shift_point);
        w_done       = (w_pos_inc >= w_len);
        w_fire       = w_map.enable && w_hit && (w_shift_fire || w_done);
        w_vis        = w_fire && (w_map.action != kcsm_pkg::ACT_GROUP);
        if (!w_hit) begin
            w_new_pos = '0;
        end else if (w_shift_fire) begin
            w_new_pos = w_pos_inc;
        end else if (w_done) begin
            w_new_pos = '0;
        end else begin
            w_new_pos = w_pos_inc;
        end

        // Profile after a fired action
        w_lim = kcsm_pkg::limit_profile(i_cfg.top_profile, MAX_PROF);
        unique case (w_map.action)
            kcsm_pkg::ACT_NEXT: w_fire_prof = (r_prof >= w_lim) ? '0 : r_prof + FW'(1);
            kcsm_pkg::ACT_PREV: w_fire_prof = (r_prof == '0) ? w_lim : r_prof - FW'(1);
            default:            w_fire_prof = r_prof;
        endcase
        w_fire_res.action      = w_map.action;
        w_fire_res.profile_now = w_fire_prof;
        w_fire_res.last        = 1'b0;
        w_last_step            = (r_idx == LAST_IDX);
    end

    // Sequencer: next state, positions, pending result and queue strobes.
    // A result is held back one fire so its last flag is known when it leaves.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_prof       = r_prof;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        o_res        = w_fire_res;

        unique case (r_state)
            kcsm_pkg::SEQ_SCAN: begin
                if (!i_cmd_empty && !i_res_full) begin
                    if (i_cmd.is_set) begin
                        n_prof            = i_cmd.set_profile;
                        o_res.action      = kcsm_pkg::ACT_SET;
                        o_res.profile_now = i_cmd.set_profile;
                        o_res.last        = 1'b1;
                        o_res_push        = 1'b1;
                        o_cmd_pop         = 1'b1;
                        n_idx             = '0;
                    end else begin
                        if (w_map.enable) begin
                            n_pos[r_idx] = w_new_pos;
                        end
                        if (w_vis) begin
                            for (int i = 0; i < NUM_SHORTCUTS; i++) begin
                                n_pos[i] = '0;
                            end
                            n_prof = w_fire_prof;
                            if (r_pend_valid) begin
                                // older result leaves, newer one waits
                                o_res        = r_pend;
                                o_res_push   = 1'b1;
                                n_pend       = w_fire_res;
                                n_pend_valid = 1'b1;
                            end else if (w_last_step) begin
                                o_res.last = 1'b1;
                                o_res_push = 1'b1;
                            end else begin
                                n_pend       = w_fire_res;
                                n_pend_valid = 1'b1;
                            end
                        end else if (w_last_step && r_pend_valid) begin
                            o_res        = r_pend;
                            o_res.last   = 1'b1;
                            o_res_push   = 1'b1;
                            n_pend_valid = 1'b0;
                        end

                        if (!w_last_step) begin
                            n_idx = r_idx + IDX_W'(1);
                        end else if (w_vis && r_pend_valid) begin
                            n_state = kcsm_pkg::SEQ_FLUSH;
                        end else begin
                            o_cmd_pop = 1'b1;
                            n_idx     = '0;
                        end
                    end
                end
            end
            kcsm_pkg::SEQ_FLUSH: begin
                if (!i_res_full) begin
                    o_res        = r_pend;
                    o_res.last   = 1'b1;
                    o_res_push   = 1'b1;
                    n_pend_valid = 1'b0;
                    o_cmd_pop    = 1'b1;
                    n_idx        = '0;
                    n_state      = kcsm_pkg::SEQ_SCAN;
                end
            end
            default: begin
                n_state = kcsm_pkg::SEQ_SCAN;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= kcsm_pkg::SEQ_SCAN;
            r_idx        <= '0;
            r_prof       <= '0;
            r_pend_valid <= 1'b0;
            for (int i = 0; i < NUM_SHORTCUTS; i++) begin
                r_pos[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_prof       <= n_prof;
            r_pend_valid <= n_pend_valid;
            r_pos        <= n_pos;
        end
    end

    // Held result payload
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

`default_nettype wire
